FILE: design/bvsa_pkg.sv
// shared types and constants for the barometric vertical speed averager
// no dependencies; imported by bvsa_div and baro_vertical_speed_averager_core
`default_nettype none

package bvsa_pkg;

    // rate ring, depth kept a power of two (two or more entries)
    localparam int RING_LOG2  = 2;
    localparam int RING_DEPTH = 1 << RING_LOG2;

    localparam int ALT_W    = 23;
    localparam int DIFF_W   = ALT_W + 1;
    localparam int MAG_W    = ALT_W;
    localparam int MS_W     = 16;
    localparam int K_W      = 10;
    localparam int DVD_W    = MAG_W + K_W;
    localparam int QUO_W    = 16;
    localparam int CNT_W    = $clog2(QUO_W);
    localparam int VS_W     = 17;
    localparam int SUM_W    = VS_W + RING_LOG2;
    localparam int VMAG_W   = 16;
    localparam int DB_W     = 10;
    localparam int SCALE_W  = 18;
    localparam int PROD_W   = VMAG_W + SCALE_W;
    localparam int RND_W    = PROD_W - 16 + 1;
    localparam int FPM_W    = 18;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [K_W-1:0]     MS_PER_S      = K_W'(1000);
    localparam logic [DB_W-1:0]    DEADBAND_RST  = DB_W'(10);
    localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(129007);
    localparam logic [FPM_W-1:0]   FPM_POS_LIMIT = FPM_W'(131071);
    localparam logic [RND_W-1:0]   FPM_NEG_MAG   = RND_W'(131072);
    localparam logic [RND_W-1:0]   FPM_POS_MAG   = RND_W'(131071);
    localparam logic [PROD_W:0]    ROUND_HALF    = (PROD_W+1)'(32768);

    // register index, taken from paddr[2]
    localparam logic REG_DEADBAND = 1'b0;
    localparam logic REG_SCALE    = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [MS_W-1:0]   divisor;
    } t_div_ctl;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: design/bvsa_div.sv
// shift and subtract divider, one quotient bit per cycle, saturating at 16 bits
// depends on bvsa_pkg
`default_nettype none

module bvsa_div import bvsa_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_ctl  i_ctl,
    output t_div_stat      o_stat
);

    logic               r_busy;
    logic               r_done;
    logic               r_sat;
    logic [CNT_W-1:0]   r_cnt;
    logic [MS_W-1:0]    r_rem;
    logic [QUO_W-1:0]   r_low;
    logic [QUO_W-1:0]   r_quo;
    logic [MS_W-1:0]    r_dvs;

    logic               sat_c;
    logic [MS_W:0]      trial;
    logic               ge;
    logic [MS_W:0]      diff;

    // quotient overflows 16 bits exactly when the upper dividend part reaches the divisor
    assign sat_c = i_ctl.dividend[DVD_W-1:QUO_W] >= {1'b0, i_ctl.divisor};
    assign trial = {r_rem, r_low[QUO_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_sat  <= sat_c;
                r_rem  <= i_ctl.dividend[QUO_W+MS_W-1:QUO_W];
                r_low  <= i_ctl.dividend[QUO_W-1:0];
                r_dvs  <= i_ctl.divisor;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= !sat_c;
                r_done <= sat_c;
            end else if (r_busy) begin
                r_rem <= ge ? diff[MS_W-1:0] : trial[MS_W-1:0];
                r_low <= {r_low[QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_sat ? '1 : r_quo;

endmodule

`default_nettype wire

FILE: design/baro_vertical_speed_averager_core.sv
// barometric vertical speed averager, top level with sequencer, rate ring and apb registers
// depends on bvsa_pkg and bvsa_div
//
// Takes one altitude word (cm) with the ms since the last sample and returns one word with
// the altitude, the ring-averaged climb rate in cm/s after the deadband, the same rate in
// feet per minute, and a time error flag in tuser. The block handles one word at a time:
// the input is ready only while the sequencer is idle. The time of a normal sample from
// accept to output is set mostly by the 16-step shift and subtract divider and the walk
// that sums the ring through one adder; a saturated rate saves the divider steps, a zero
// elapsed time skips the divider and the first sample after reset primes the previous
// altitude and goes straight to a zero rate. A finished word waits in the output register
// while the next sample is taken. Registers: deadband at address 0x0, fpm scale (Q16) at
// 0x4.
`default_nettype none

module baro_vertical_speed_averager_core import bvsa_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave stream
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_DATA_W-1:0]  i_s_axis_tdata,  // altitude_cm[22:0], elapsed_ms[38:23]
    // master stream
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [M_DATA_W-1:0]       o_m_axis_tdata,  // altitude_out_cm[22:0],
                                                       // vspeed_cm_per_s[39:23],
                                                       // vspeed_fpm[57:40]
    output logic                      o_m_axis_tuser,  // time_error
    // apb registers
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_SUM,
        ST_AVG,
        ST_FPM,
        ST_OUT
    } t_state;

    t_state                       r_state;
    logic                         r_primed;
    logic                         r_first;
    logic                         r_err;
    logic signed [ALT_W-1:0]      r_alt;
    logic signed [ALT_W-1:0]      r_prev;
    logic [MS_W-1:0]              r_elapsed;
    logic [DVD_W-1:0]             r_dvd;
    logic                         r_neg;
    logic signed [VS_W-1:0]       r_ring [RING_DEPTH];
    logic [RING_LOG2-1:0]         r_ptr;
    logic [RING_LOG2-1:0]         r_idx;
    logic signed [SUM_W-1:0]      r_sum;
    logic [VMAG_W-1:0]            r_vmag;
    logic                         r_vneg;
    logic [PROD_W-1:0]            r_prod;
    logic [DB_W-1:0]              r_deadband;
    logic [SCALE_W-1:0]           r_scale;
    logic                         r_m_valid;
    logic signed [ALT_W-1:0]      r_out_alt;
    logic signed [VS_W-1:0]       r_out_vs;
    logic signed [FPM_W-1:0]      r_out_fpm;
    logic                         r_out_err;

    t_div_ctl                     div_ctl;
    t_div_stat                    div_stat;

    logic                         s_acc;
    logic                         cfg_wr;
    logic signed [DIFF_W-1:0]     alt_diff;
    logic [MAG_W-1:0]             diff_mag;
    logic signed [VS_W-1:0]       rate;
    logic [SUM_W-1:0]             sum_mag;
    logic [VMAG_W-1:0]            avg_mag;
    logic [PROD_W:0]              prod_rnd;
    logic [RND_W-1:0]             fpm_mag;
    logic signed [FPM_W-1:0]      fpm_val;
    logic signed [VS_W-1:0]       vs_val;
    logic                         out_free;

    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign alt_diff = DIFF_W'(r_alt) - DIFF_W'(r_prev);
    assign diff_mag = alt_diff[DIFF_W-1] ? MAG_W'(-alt_diff) : MAG_W'(alt_diff);

    assign div_ctl.start    = (r_state == ST_START);
    assign div_ctl.dividend = r_dvd;
    assign div_ctl.divisor  = r_elapsed;

    assign rate = r_neg ? -VS_W'(div_stat.quotient) : VS_W'(div_stat.quotient);

    // average truncates toward zero, so shift the magnitude
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign avg_mag = VMAG_W'(sum_mag >> RING_LOG2);

    // round half away from zero on the magnitude, then saturate per sign
    assign prod_rnd = (PROD_W+1)'(r_prod) + ROUND_HALF;
    assign fpm_mag  = prod_rnd[PROD_W:16];
    always_comb begin
        if (r_vneg) begin
            fpm_val = (fpm_mag > FPM_NEG_MAG) ? $signed({1'b1, {(FPM_W-1){1'b0}}})
                                              : -FPM_W'(fpm_mag);
        end else begin
            fpm_val = (fpm_mag > FPM_POS_MAG) ? $signed(FPM_POS_LIMIT) : FPM_W'(fpm_mag);
        end
    end
    assign vs_val = r_vneg ? -VS_W'(r_vmag) : VS_W'(r_vmag);

    assign out_free = !r_m_valid || i_m_axis_tready;

    bvsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_stat  (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_primed   <= 1'b0;
            r_prev     <= '0;
            r_ptr      <= '0;
            r_idx      <= '0;
            r_m_valid  <= 1'b0;
            r_deadband <= DEADBAND_RST;
            r_scale    <= SCALE_RST;
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_DEADBAND: r_deadband <= pwdata[DB_W-1:0];
                    REG_SCALE:    r_scale    <= pwdata[SCALE_W-1:0];
                    default:      r_deadband <= r_deadband;
                endcase
            end

            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_alt     <= i_s_axis_tdata[ALT_W-1:0];
                        r_elapsed <= i_s_axis_tdata[ALT_W+MS_W-1:ALT_W];
                        r_first   <= !r_primed;
                        r_err     <= r_primed && (i_s_axis_tdata[ALT_W+MS_W-1:ALT_W] == '0);
                        r_primed  <= 1'b1;
                        r_state   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_dvd  <= DVD_W'(diff_mag) * DVD_W'(MS_PER_S);
                    r_neg  <= alt_diff[DIFF_W-1];
                    r_prev <= r_alt;
                    r_sum  <= '0;
                    r_idx  <= '0;
                    if (r_first) begin
                        r_vmag  <= '0;
                        r_vneg  <= 1'b0;
                        r_state <= ST_FPM;
                    end else if (r_err) begin
                        r_state <= ST_SUM;
                    end else begin
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        r_ring[r_ptr] <= rate;
                        r_ptr         <= r_ptr + 1'b1;
                        r_state       <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_sum <= r_sum + SUM_W'(r_ring[r_idx]);
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == RING_LOG2'(RING_DEPTH - 1)) begin
                        r_state <= ST_AVG;
                    end
                end
                ST_AVG: begin
                    if (avg_mag < VMAG_W'(r_deadband)) begin
                        r_vmag <= '0;
                        r_vneg <= 1'b0;
                    end else begin
                        r_vmag <= avg_mag;
                        r_vneg <= r_sum[SUM_W-1];
                    end
                    r_state <= ST_FPM;
                end
                ST_FPM: begin
                    r_prod  <= PROD_W'(r_vmag) * PROD_W'(r_scale);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_alt <= r_alt;
                        r_out_vs  <= vs_val;
                        r_out_fpm <= fpm_val;
                        r_out_err <= r_err;
                        r_m_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_DATA_W-ALT_W-VS_W-FPM_W){1'b0}}, r_out_fpm, r_out_vs,
                              r_out_alt};
    assign o_m_axis_tuser  = r_out_err;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCALE) ? APB_DW'(r_scale) : APB_DW'(r_deadband);

`ifndef SYNTHESIS
    // the divider is never started with a zero time base
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> (r_elapsed != '0))
        else $error("divider started with zero elapsed time");

    // the ring pointer moves by one exactly when a rate is written
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && div_stat.done) |=> (r_ptr == $past(r_ptr) + 1'b1))
        else $error("ring pointer did not advance on rate write");

    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_DIV && div_stat.done) |=> $stable(r_ptr))
        else $error("ring pointer moved without a rate write");

    // a new output word only comes out of the final sequencer step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == ST_OUT))
        else $error("output word loaded outside the output step");

    // a time error word never carries a fresh divider result
    a_err_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_err && !r_first)
        else $error("divider path taken for an error or priming sample");
`endif

endmodule

`default_nettype wire
